[design/glos_pkg.sv]
// Shared constants and types for the grid line-of-sight block.
// Used by glos_map and grid_line_of_sight; depends on nothing.
package glos_pkg;

  // Map and coordinate format
  localparam int MAP_DIM    = 64;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 24;

  // Fixed field widths
  localparam int ROW_BITS     = 64;
  localparam int ROW_SEL_BITS = 6;
  localparam int CFG_BITS     = 7;
  localparam int CFG_IDX_BITS = 1;

  // Derived widths
  localparam int ADDR_BITS    = (MAP_DIM > 1) ? $clog2(MAP_DIM) : 1;
  localparam int DIM_BITS     = $clog2(MAP_DIM + 1);
  localparam int LIMIT_BITS   = $clog2(2 * MAP_DIM + 3);
  localparam int ROW_IDX_BITS = $clog2(ROW_BITS);
  localparam int INT_BITS     = (COORD_BITS > FRAC_BITS) ? (COORD_BITS - FRAC_BITS) : 1;
  localparam int TILE_BASE    = (INT_BITS > DIM_BITS) ? INT_BITS : DIM_BITS;
  localparam int TILE_BITS    = ((TILE_BASE > ROW_IDX_BITS) ? TILE_BASE : ROW_IDX_BITS) + 2;
  localparam int NX_BITS      = FRAC_BITS + 1;
  localparam int PROD_BITS    = COORD_BITS + NX_BITS;
  localparam int D_BITS       = COORD_BITS + FRAC_BITS + $clog2(2 * MAP_DIM + 4) + 1;

  localparam logic [NX_BITS-1:0] FX_ONE = NX_BITS'(1) << FRAC_BITS;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT = 1'b1;

  // Item kinds
  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Write request into the wall map
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [ROW_BITS-1:0]  data;
  } map_wr_t;

endpackage

[design/glos_map.sv]
// Wall map storage: one row of wall bits per entry, one write and one read port.
// Uses glos_pkg; rows never written since reset read as all clear.
module glos_map (
  input  logic                          clk,
  input  logic                          rst,
  input  glos_pkg::map_wr_t             wr,
  input  logic [glos_pkg::ADDR_BITS-1:0] rd_addr,
  output logic [glos_pkg::ROW_BITS-1:0]  rd_data
);
  import glos_pkg::*;

  logic [ROW_BITS-1:0] mem [MAP_DIM];
  logic [MAP_DIM-1:0]  row_valid;
  logic [ROW_BITS-1:0] rd_q;
  logic                rd_valid_q;

  // Write a row
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Mark written rows; reset forgets them all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_q       <= mem[rd_addr];
    rd_valid_q <= row_valid[rd_addr];
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

[design/grid_line_of_sight.sv]
// Grid line-of-sight block: wall map loading, register port and the cell walk.
// Uses glos_pkg and glos_map.
// A row write returns nothing. A query passes the setup states (prep, multiply, init),
// then one step state per x step, plus a row-load state per y or diagonal step (map
// read), and then the output register.
// One query walks at a time and no item is taken while it walks; the map read port sets the per-step cost.
// Reset clears the wall map at once and sets width and height to the full map.
module grid_line_of_sight (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic [glos_pkg::ROW_SEL_BITS-1:0]     row_index,
  input  logic [glos_pkg::ROW_BITS-1:0]         row_walls,
  input  logic signed [glos_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [glos_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [glos_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [glos_pkg::COORD_BITS-1:0] end_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  visible,
  input  logic                                  cfg_write,
  input  logic [glos_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [glos_pkg::CFG_BITS-1:0]         cfg_data
);
  import glos_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_MULT = 7'b0000100,
    S_INIT = 7'b0001000,
    S_STEP = 7'b0010000,
    S_LOAD = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // Clamp a register value to the map size
  function automatic logic [DIM_BITS-1:0] dim_clamp(input logic [CFG_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    if (v > CFG_BITS'(MAP_DIM)) begin
      r = DIM_BITS'(MAP_DIM);
    end else begin
      r = DIM_BITS'(v);
    end
    return r;
  endfunction

  // Wall test of one cell, given the row that holds it
  function automatic logic wall_at(input logic signed [TILE_BITS-1:0] x,
                                   input logic signed [TILE_BITS-1:0] y,
                                   input logic [ROW_BITS-1:0] row,
                                   input logic [DIM_BITS-1:0] w,
                                   input logic [DIM_BITS-1:0] h);
    logic outside;
    outside = x[TILE_BITS-1] || y[TILE_BITS-1] ||
              ($unsigned(x) >= TILE_BITS'(w)) || ($unsigned(y) >= TILE_BITS'(h));
    return outside || row[x[ROW_IDX_BITS-1:0]];
  endfunction

  state_t state;

  logic [DIM_BITS-1:0] map_width;
  logic [DIM_BITS-1:0] map_height;

  // Query registers
  logic signed [COORD_BITS-1:0] fx, fy, tx, ty;
  logic signed [TILE_BITS-1:0]  cx, cy, gx, gy, side_x;
  logic                         x_neg, y_neg, x_move, y_move;
  logic [COORD_BITS-1:0]        adx, ady;
  logic [NX_BITS-1:0]           nx0, ny0;
  logic [PROD_BITS-1:0]         prod_a, prod_b;
  logic signed [D_BITS-1:0]     dsum;
  logic [LIMIT_BITS-1:0]        steps, limit;
  logic [ROW_BITS-1:0]          cur_row;
  logic                         result;

  // Map port
  map_wr_t                map_wr;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [ROW_BITS-1:0]    rd_data;

  // Combinational helpers
  logic                         in_fire, load_out;
  logic signed [COORD_BITS:0]   dx, dy;
  logic                         go_x, go_y;
  logic signed [TILE_BITS-1:0]  cx_step, cy_step, ncx, ncy;
  logic                         side_wall, step_reached, load_wall, cell_reached;
  logic [LIMIT_BITS-1:0]        steps_inc;
  logic signed [D_BITS-1:0]     inc_x, inc_y;

  glos_map u_map (
    .clk     (clk),
    .rst     (rst),
    .wr      (map_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // Row writes go straight into the map; rows beyond the map are dropped
  always_comb begin
    map_wr.en   = in_fire && (kind == KIND_ROW) &&
                  ({1'b0, row_index} < (ROW_SEL_BITS + 1)'(MAP_DIM));
    map_wr.addr = row_index[ADDR_BITS-1:0];
    map_wr.data = row_walls;
  end

  // Setup arithmetic
  assign dx = (COORD_BITS + 1)'(tx) - (COORD_BITS + 1)'(fx);
  assign dy = (COORD_BITS + 1)'(ty) - (COORD_BITS + 1)'(fy);

  // Step choice: sign of nx*ady - ny*adx picks the axis, zero means diagonal
  always_comb begin
    go_x      = x_move && (!y_move || dsum[D_BITS-1] || (dsum == '0));
    go_y      = y_move && (!x_move || !dsum[D_BITS-1]);
    cx_step   = x_neg ? (cx - TILE_BITS'(1)) : (cx + TILE_BITS'(1));
    cy_step   = y_neg ? (cy - TILE_BITS'(1)) : (cy + TILE_BITS'(1));
    ncx       = go_x ? cx_step : cx;
    ncy       = go_y ? cy_step : cy;
    inc_x     = $signed(D_BITS'(ady) << FRAC_BITS);
    inc_y     = $signed(D_BITS'(adx) << FRAC_BITS);
    steps_inc = steps + LIMIT_BITS'(1);
    // new cell of an x step, or the x side cell of a diagonal step, both on the current row
    side_wall    = wall_at(ncx, cy, cur_row, map_width, map_height);
    step_reached = (ncx == gx) && (ncy == gy);
    // after a row load: the new cell and the y side cell (same cell for a y step)
    load_wall    = wall_at(cx, cy, rd_data, map_width, map_height) ||
                   wall_at(side_x, cy, rd_data, map_width, map_height);
    cell_reached = (cx == gx) && (cy == gy);
  end

  // Read the start row ahead of the walk, then the row entered by each y step
  assign rd_addr = (state == S_STEP) ? ncy[ADDR_BITS-1:0] : cy[ADDR_BITS-1:0];

  // Registers and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      map_width  <= DIM_BITS'(MAP_DIM);
      map_height <= DIM_BITS'(MAP_DIM);
    end else begin
      // Configuration writes
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAP_WIDTH:  map_width  <= dim_clamp(cfg_data);
          REG_MAP_HEIGHT: map_height <= dim_clamp(cfg_data);
          default: ;
        endcase
      end

      // Output register: load a finished result, drop a taken one
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire && (kind == KIND_QUERY)) begin
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_MULT;
        S_MULT: state <= S_INIT;
        S_INIT: begin
          if (cell_reached) begin
            state <= S_DONE;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (go_y) begin
            if (go_x && side_wall) begin
              state <= S_DONE;
            end else begin
              state <= S_LOAD;
            end
          end else if (side_wall || step_reached || (steps_inc == limit)) begin
            state <= S_DONE;
          end
        end
        S_LOAD: begin
          if (load_wall || cell_reached || (steps == limit)) begin
            state <= S_DONE;
          end else begin
            state <= S_STEP;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    if (load_out) begin
      visible <= result;
    end
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          fx <= start_x;
          fy <= start_y;
          tx <= end_x;
          ty <= end_y;
        end
      end
      S_PREP: begin
        // floor to tiles, step signs, magnitudes and distances to the first boundaries
        cx     <= TILE_BITS'(fx >>> FRAC_BITS);
        cy     <= TILE_BITS'(fy >>> FRAC_BITS);
        gx     <= TILE_BITS'(tx >>> FRAC_BITS);
        gy     <= TILE_BITS'(ty >>> FRAC_BITS);
        x_neg  <= dx[COORD_BITS];
        y_neg  <= dy[COORD_BITS];
        x_move <= (dx != '0);
        y_move <= (dy != '0);
        adx    <= dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady    <= dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        if (dx == '0) begin
          nx0 <= '0;
        end else if (dx[COORD_BITS]) begin
          nx0 <= {1'b0, fx[FRAC_BITS-1:0]};
        end else begin
          nx0 <= FX_ONE - {1'b0, fx[FRAC_BITS-1:0]};
        end
        if (dy == '0) begin
          ny0 <= '0;
        end else if (dy[COORD_BITS]) begin
          ny0 <= {1'b0, fy[FRAC_BITS-1:0]};
        end else begin
          ny0 <= FX_ONE - {1'b0, fy[FRAC_BITS-1:0]};
        end
      end
      S_MULT: begin
        prod_a <= PROD_BITS'(nx0) * PROD_BITS'(ady);
        prod_b <= PROD_BITS'(ny0) * PROD_BITS'(adx);
      end
      S_INIT: begin
        dsum    <= $signed(D_BITS'(prod_a)) - $signed(D_BITS'(prod_b));
        cur_row <= rd_data;
        steps   <= '0;
        limit   <= LIMIT_BITS'(map_width) + LIMIT_BITS'(map_height) + LIMIT_BITS'(2);
        result  <= 1'b1;
      end
      S_STEP: begin
        // advance one crossing; keep the crossing difference exact
        dsum   <= dsum + (go_x ? inc_x : '0) - (go_y ? inc_y : '0);
        side_x <= cx;
        cx     <= ncx;
        cy     <= ncy;
        steps  <= steps_inc;
        if (go_y) begin
          result <= 1'b0;
        end else begin
          result <= !side_wall && step_reached;
        end
      end
      S_LOAD: begin
        cur_row <= rd_data;
        result  <= !load_wall && cell_reached;
      end
      S_DONE: ;
      default: ;
    endcase
  end

endmodule

[design/glos_checker.sv]
// Port-level checks for the grid line-of-sight block, bound to its top level.
// Depends only on the top level's ports.
module glos_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic kind,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);

  // Hold a result until it is taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible))
    else $error("result changed or dropped while stalled");

  // A query occupies the walker, so the next item must wait
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind |=> !in_ready)
    else $error("item accepted while a query is walking");

  // A row write does not stall the input
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> in_ready)
    else $error("row write stalled the input");

  // A new result appears only as the walker goes idle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while the walker was busy");

endmodule

bind grid_line_of_sight glos_checker u_glos_checker (.*);

[sim/grid_line_of_sight_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for grid_line_of_sight: loads wall rows, changes the map size
// and checks each line-of-sight answer against a cell-walk predictor kept in the bench.
// Depends on glos_pkg and the grid_line_of_sight RTL.
module grid_line_of_sight_tb;
  import glos_pkg::*;

  localparam longint ONE    = longint'(1) << FRAC_BITS;
  localparam longint HALF   = ONE / 2;
  localparam longint C_MIN  = -(longint'(1) << (COORD_BITS - 1));
  localparam longint C_MAX  = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam int     PHASES = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef enum {BY_MODEL, SEEN, HIDDEN} verdict_t;

  typedef struct {
    logic                    kind;
    logic [ROW_SEL_BITS-1:0] row;
    logic [ROW_BITS-1:0]     walls;
    longint                  sx, sy, ex, ey;
    verdict_t                verdict;
  } probe_t;

  typedef struct {
    bit          visible;
    int unsigned query_no;
  } sight_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    kind;
  logic [ROW_SEL_BITS-1:0] row_index;
  logic [ROW_BITS-1:0]     row_walls;
  coord_t                  start_x, start_y, end_x, end_y;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    visible;
  logic                    cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  // Shadow of the block state
  logic [ROW_BITS-1:0] wall_map [MAP_DIM];
  logic [CFG_BITS-1:0] model_width, model_height;
  sight_t              vis_expect_q [$];

  int unsigned queries_sent, rows_sent, results_seen, visible_seen, mismatches, sizes_run;
  bit          rx_calm, tx_calm;
  int unsigned rx_hold;

  // Directed items: extremes, outside tiles, corner crossings, boundaries
  probe_t probes [24] = '{
    '{KIND_QUERY, 6'd0, 64'd0, HALF, HALF, HALF + 100, HALF - 100, SEEN},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, HALF, -HALF, HALF, HIDDEN},
    '{KIND_QUERY, 6'd0, 64'd0, C_MIN, C_MIN, C_MAX, C_MAX, HIDDEN},
    '{KIND_QUERY, 6'd0, 64'd0, C_MAX, C_MAX, C_MIN, C_MIN, HIDDEN},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, HALF, C_MAX, C_MAX, HIDDEN},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, HALF, 63 * ONE + HALF, 63 * ONE + HALF, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, HALF, 63 * ONE + HALF, HALF, BY_MODEL},
    '{KIND_ROW, 6'd0, 64'd0, 0, 0, 0, 0, BY_MODEL},
    '{KIND_ROW, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, 62 * ONE + HALF, HALF, 63 * ONE + HALF, HIDDEN},
    '{KIND_ROW, 6'd5, 64'h8000_0000_0000_0001, 0, 0, 0, 0, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, 5 * ONE + HALF, 3 * ONE + HALF, 5 * ONE + HALF,
      BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, 63 * ONE + HALF, 4 * ONE + HALF, 63 * ONE + HALF,
      6 * ONE + HALF, HIDDEN},
    '{KIND_ROW, 6'd10, 64'h0000_0000_0000_0400, 0, 0, 0, 0, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, 10 * ONE + HALF, 9 * ONE + HALF, 11 * ONE + HALF,
      10 * ONE + HALF, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, 20 * ONE + HALF, 9 * ONE + HALF, 21 * ONE + HALF,
      10 * ONE + HALF, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, 2 * ONE, 3 * ONE, 0, HALF, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, -ONE / 4, ONE + HALF, ONE + HALF, ONE + HALF, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, 30 * ONE + HALF, 40 * ONE + HALF, 30 * ONE + HALF,
      2 * ONE + 7, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, 3 * ONE + 123, 2 * ONE + 999, 5 * ONE + 45678,
      60 * ONE + 3, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, 50 * ONE + 11, 50 * ONE + 22, 4 * ONE + 60000,
      9 * ONE + 1, BY_MODEL},
    '{KIND_ROW, 6'd42, 64'hAAAA_5555_F0F0_0F0F, 0, 0, 0, 0, BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, 42 * ONE + HALF, 63 * ONE + HALF, 42 * ONE + HALF,
      BY_MODEL},
    '{KIND_QUERY, 6'd0, 64'd0, HALF, HALF, 64 * ONE + HALF, HALF, HIDDEN}
  };

  grid_line_of_sight dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .row_index (row_index),
    .row_walls (row_walls),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visible   (visible),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a size register to the map
  function automatic longint used_dim(logic [CFG_BITS-1:0] v);
    return (v > MAP_DIM) ? longint'(MAP_DIM) : longint'(v);
  endfunction

  // Tiles off the configured map are walls
  function automatic bit is_blocked(longint x, longint y);
    if (x < 0 || y < 0) return 1'b1;
    if (x >= used_dim(model_width) || y >= used_dim(model_height)) return 1'b1;
    return wall_map[y][x];
  endfunction

  // Walk the cells from start tile to target tile and report whether the target is seen
  function automatic bit trace_sight(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint fx, fy, cx, cy, gx, gy, dx, dy, stx, sty, adx, ady, nx, ny;
    longint lhs, rhs, steps, i;
    fx = longint'(sx);
    fy = longint'(sy);
    cx = fx >>> FRAC_BITS;
    cy = fy >>> FRAC_BITS;
    gx = longint'(ex) >>> FRAC_BITS;
    gy = longint'(ey) >>> FRAC_BITS;
    dx = longint'(ex) - fx;
    dy = longint'(ey) - fy;
    stx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
    sty = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (cx == gx && cy == gy) return 1'b1;
    // distance to the first boundary in each direction of travel
    nx = 0;
    ny = 0;
    if (stx > 0) nx = (cx + 1) * ONE - fx;
    else if (stx < 0) nx = fx - cx * ONE;
    if (sty > 0) ny = (cy + 1) * ONE - fy;
    else if (sty < 0) ny = fy - cy * ONE;
    steps = used_dim(model_width) + used_dim(model_height) + 2;
    for (i = 0; i < steps; i++) begin
      if (adx == 0) begin
        cy += sty;
        ny += ONE;
      end else if (ady == 0) begin
        cx += stx;
        nx += ONE;
      end else begin
        lhs = nx * ady;
        rhs = ny * adx;
        if (lhs < rhs) begin
          cx += stx;
          nx += ONE;
        end else if (lhs > rhs) begin
          cy += sty;
          ny += ONE;
        end else begin
          // exact corner: both side cells must be open
          if (is_blocked(cx + stx, cy) || is_blocked(cx, cy + sty)) return 1'b0;
          cx += stx;
          cy += sty;
          nx += ONE;
          ny += ONE;
        end
      end
      if (is_blocked(cx, cy)) return 1'b0;
      if (cx == gx && cy == gy) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p < 15) return $urandom_range(1, 3);
    if (p < 19) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic coord_t fx_point(longint tile, longint frac);
    return coord_t'(tile * ONE + frac);
  endfunction

  // Favor tile centers and exact boundaries
  function automatic longint pick_frac();
    case ($urandom_range(0, 5))
      0, 1: return HALF;
      2: return 0;
      default: return longint'($urandom_range(0, ONE - 1));
    endcase
  endfunction

  // Mostly on the map, now and then just off it
  function automatic longint pick_tile(longint dim);
    if ($urandom_range(0, 9) == 0) return longint'($urandom_range(0, dim + 3)) - 2;
    return longint'($urandom_range(0, dim - 1));
  endfunction

  function automatic logic [ROW_BITS-1:0] pick_walls();
    logic [ROW_BITS-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0, 1: return '0;
      2: return '1;
      3, 4: return a;
      5, 6, 7, 8: return a & b;
      default: return a & b & c;
    endcase
  endfunction

  task automatic log_mismatch(string msg);
    if (mismatches < 10) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Present one item, hold it until taken, then update the shadow state
  task automatic send_item(logic k, logic [ROW_SEL_BITS-1:0] r, logic [ROW_BITS-1:0] w,
                           coord_t a, coord_t b, coord_t c, coord_t d, verdict_t v);
    sight_t answer;
    in_valid  <= 1'b1;
    kind      <= k;
    row_index <= r;
    row_walls <= w;
    start_x   <= a;
    start_y   <= b;
    end_x     <= c;
    end_y     <= d;
    do @(posedge clk); while (!in_ready);
    if (k == KIND_ROW) begin
      wall_map[r] = w;
      rows_sent++;
    end else begin
      answer.visible  = (v == BY_MODEL) ? trace_sight(a, b, c, d) : (v == SEEN);
      answer.query_no = queries_sent;
      queries_sent++;
      vis_expect_q.insert(vis_expect_q.size(), answer);
    end
  endtask

  task automatic hold_off(int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait for every pending answer, then let a trailing row write settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (vis_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_map_size(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    model_width = w;
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    model_height = h;
    cfg_write <= 1'b0;
    sizes_run++;
  endtask

  task automatic send_random_row(longint h_dim);
    logic [ROW_SEL_BITS-1:0] r;
    if ($urandom_range(0, 3) != 0) r = ROW_SEL_BITS'($urandom_range(0, h_dim - 1));
    else r = ROW_SEL_BITS'($urandom_range(0, MAP_DIM - 1));
    send_item(KIND_ROW, r, pick_walls(), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), BY_MODEL);
  endtask

  task automatic send_random_query(longint w_dim, longint h_dim);
    longint tx0, ty0, tx1, ty1, k, fr, sgx, sgy;
    coord_t a, b, c, d;
    tx0 = pick_tile(w_dim);
    ty0 = pick_tile(h_dim);
    case ($urandom_range(0, 9))
      0: begin
        // noise over the whole coordinate range
        a = coord_t'($urandom);
        b = coord_t'($urandom);
        c = coord_t'($urandom);
        d = coord_t'($urandom);
      end
      1: begin
        // both points in one tile
        a = fx_point(tx0, pick_frac());
        b = fx_point(ty0, pick_frac());
        c = fx_point(tx0, pick_frac());
        d = fx_point(ty0, pick_frac());
      end
      2, 3: begin
        // 45 degree line: every crossing is a corner
        k   = $urandom_range(1, 10);
        sgx = $urandom_range(0, 1) ? 1 : -1;
        sgy = $urandom_range(0, 1) ? 1 : -1;
        fr  = (sgx == sgy) ? pick_frac() : HALF;
        a = fx_point(tx0, fr);
        b = fx_point(ty0, fr);
        c = fx_point(tx0 + sgx * k, fr);
        d = fx_point(ty0 + sgy * k, fr);
      end
      default: begin
        if ($urandom_range(0, 1) != 0) begin
          tx1 = tx0 + longint'($urandom_range(0, 6)) - 3;
          ty1 = ty0 + longint'($urandom_range(0, 6)) - 3;
        end else begin
          tx1 = pick_tile(w_dim);
          ty1 = pick_tile(h_dim);
        end
        a = fx_point(tx0, pick_frac());
        b = fx_point(ty0, pick_frac());
        c = fx_point(tx1, pick_frac());
        d = fx_point(ty1, pick_frac());
      end
    endcase
    send_item(KIND_QUERY, ROW_SEL_BITS'($urandom_range(0, MAP_DIM - 1)),
              {$urandom, $urandom}, a, b, c, d, BY_MODEL);
  endtask

  // Output side: random stalls with calm stretches
  always @(posedge clk) begin : pace_output
    if ($urandom_range(0, 299) == 0) rx_calm = ~rx_calm;
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      rx_hold = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each answer with the oldest pending one
  always @(posedge clk) begin : check_results
    sight_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (visible) visible_seen++;
      if (vis_expect_q.size() == 0) begin
        log_mismatch($sformatf("visible=%0b with no query pending", visible));
      end else begin
        want = vis_expect_q.pop_front();
        if (visible !== want.visible)
          log_mismatch($sformatf("query %0d: expected visible=%0b, got %0b",
                                 want.query_no, want.visible, visible));
      end
    end
  end

  initial begin : stimulus
    int unsigned n, p;
    longint      wd, hd;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    kind      <= KIND_ROW;
    row_index <= '0;
    row_walls <= '0;
    start_x   <= '0;
    start_y   <= '0;
    end_x     <= '0;
    end_y     <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data  <= '0;
    foreach (wall_map[i]) wall_map[i] = '0;
    model_width  = CFG_BITS'(MAP_DIM);
    model_height = CFG_BITS'(MAP_DIM);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed items at the reset map size
    foreach (probes[i]) begin
      send_item(probes[i].kind, probes[i].row, probes[i].walls,
                coord_t'(probes[i].sx), coord_t'(probes[i].sy),
                coord_t'(probes[i].ex), coord_t'(probes[i].ey), probes[i].verdict);
      hold_off(($urandom_range(0, 2) == 0) ? idle_len() : 0);
    end
    drain_results();

    // Random phases, one map size each
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_map_size(7'd1, 7'd1);
        1: set_map_size(7'd0, 7'd9);
        2: set_map_size(7'd127, 7'd100);
        3: set_map_size(7'd8, 7'd8);
        4: set_map_size(7'd65, 7'd3);
        5: set_map_size(7'd17, 7'd40);
        6: set_map_size(7'd12, 7'd0);
        7: set_map_size(7'd2, 7'd64);
        8: set_map_size(CFG_BITS'($urandom_range(1, 127)),
                        CFG_BITS'($urandom_range(1, 127)));
        default: set_map_size(7'd64, 7'd64);
      endcase
      wd = (used_dim(model_width) == 0) ? 1 : used_dim(model_width);
      hd = (used_dim(model_height) == 0) ? 1 : used_dim(model_height);
      for (n = 0; n < 185; n++) begin
        if (n < 12 || $urandom_range(0, 4) == 0) send_random_row(hd);
        else send_random_query(wd, hd);
        if ($urandom_range(0, 79) == 0) tx_calm = ~tx_calm;
        if ($urandom_range(0, 149) == 0) drain_results();
        else hold_off((!tx_calm && $urandom_range(0, 2) == 0) ? idle_len() : 0);
      end
      drain_results();
    end

    // Let any stray answer show up before judging
    repeat (300) @(posedge clk);
    $display("Covered %0d wall rows and %0d queries (%0d seen) over %0d map sizes,",
             rows_sent, queries_sent, visible_seen, sizes_run);
    $display("with random input gaps and output stalls; %0d answers checked.", results_seen);
    if (mismatches == 0 && vis_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #(30_000_000);
    $display("Timeout with %0d answers pending", vis_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
